// File: src/eth_header_classify_reply_unit_assert.svh
// Assertion macros used by the reply stage RTL of the header classifier.
`ifndef ETH_HEADER_CLASSIFY_REPLY_UNIT_ASSERT_SVH
`define ETH_HEADER_CLASSIFY_REPLY_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define EHC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Antecedent implies consequent in the following cycle.
`define EHC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define EHC_ASSERT_SAME(label, clk, rstn, ante, cons)
`define EHC_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// File: src/ehc_pkg.sv
package ehc_pkg;

    typedef enum logic [1:0] {
        CLASS_NONE = 2'd0,
        CLASS_ARP  = 2'd1,
        CLASS_IP   = 2'd2
    } frame_class_t;

    typedef enum logic [1:0] {
        CFG_LOCAL_MAC = 2'd0,
        CFG_IP_TYPE   = 2'd1,
        CFG_ARP_TYPE  = 2'd2
    } cfg_index_t;

    localparam logic [15:0] IP_TYPE_RST  = 16'h0800;
    localparam logic [15:0] ARP_TYPE_RST = 16'h0806;

    localparam logic [3:0] POS_MAC_END  = 4'd6;
    localparam logic [3:0] POS_SRC_END  = 4'd12;
    localparam logic [3:0] POS_TYPE_HI  = 4'd12;
    localparam logic [3:0] POS_TYPE_LO  = 4'd13;
    localparam logic [3:0] POS_DONE     = 4'd14;
    localparam logic [3:0] HDR_MAC_END  = 4'd6;
    localparam logic [3:0] HDR_SRC_END  = 4'd12;
    localparam logic [3:0] HDR_TYPE_HI  = 4'd12;
    localparam logic [3:0] HDR_LAST     = 4'd13;

    typedef struct packed {
        logic [47:0] local_mac;
        logic [15:0] ip_type;
        logic [15:0] arp_type;
    } cfg_t;

    // One classified frame, waiting to be turned into results.
    typedef struct packed {
        frame_class_t cls;
        logic [47:0]  req_mac;
        logic [15:0]  etype;
    } evt_t;

    // Status of the result stage as seen by the parser.
    typedef struct packed {
        logic hold;
    } reply_stat_t;

    // Byte idx of a MAC address in wire order; byte 0 is in the top bits.
    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            3'd0: b = mac[47:40];
            3'd1: b = mac[39:32];
            3'd2: b = mac[31:24];
            3'd3: b = mac[23:16];
            3'd4: b = mac[15:8];
            3'd5: b = mac[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: src/ehc_cfg_regs.sv
module ehc_cfg_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_addr,
    input  logic [47:0]   cfg_wdata,
    output ehc_pkg::cfg_t cfg
);

    ehc_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.local_mac <= 48'd0;
            cfg_reg.ip_type   <= ehc_pkg::IP_TYPE_RST;
            cfg_reg.arp_type  <= ehc_pkg::ARP_TYPE_RST;
        end else if (cfg_valid) begin
            case (cfg_addr)
                ehc_pkg::CFG_LOCAL_MAC: cfg_reg.local_mac <= cfg_wdata;
                ehc_pkg::CFG_IP_TYPE:   cfg_reg.ip_type   <= cfg_wdata[15:0];
                ehc_pkg::CFG_ARP_TYPE:  cfg_reg.arp_type  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

endmodule

// File: src/ehc_parser.sv
module ehc_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tuser,
    input  ehc_pkg::cfg_t        cfg,
    input  ehc_pkg::reply_stat_t stat,
    output logic                 evt_load,
    output ehc_pkg::evt_t        evt
);

    logic [3:0]  pos_reg, pos_next, pos_eff;
    logic        match_reg, match_next, match_eff;
    logic [47:0] req_reg, req_next;
    logic [7:0]  type_hi_reg, type_hi_next;
    logic [15:0] etype;
    logic        accept;

    // Only position 13 makes results, so a byte arriving there waits for the
    // result stage, even one that opens a new frame.
    assign s_tready = !((pos_reg == ehc_pkg::POS_TYPE_LO) && stat.hold);
    assign accept   = s_tvalid && s_tready;

    assign pos_eff   = s_tuser ? 4'd0 : pos_reg;
    assign match_eff = s_tuser ? 1'b1 : match_reg;
    assign etype     = {type_hi_reg, s_tdata};

    always_comb begin
        pos_next     = pos_reg;
        match_next   = match_reg;
        req_next     = req_reg;
        type_hi_next = type_hi_reg;
        if (accept) begin
            match_next = match_eff;
            if (pos_eff < ehc_pkg::POS_MAC_END) begin
                if (s_tdata != ehc_pkg::mac_byte(cfg.local_mac, pos_eff[2:0])) begin
                    match_next = 1'b0;
                end
            end else if (pos_eff < ehc_pkg::POS_SRC_END) begin
                req_next = {req_reg[39:0], s_tdata};
            end else if (pos_eff == ehc_pkg::POS_TYPE_HI) begin
                type_hi_next = s_tdata;
            end
            pos_next = (pos_eff < ehc_pkg::POS_DONE) ? pos_eff + 4'd1 : ehc_pkg::POS_DONE;
        end
    end

    assign evt_load = accept && (pos_eff == ehc_pkg::POS_TYPE_LO);

    always_comb begin
        evt.req_mac = req_reg;
        evt.etype   = etype;
        if (etype == cfg.arp_type) begin
            evt.cls = ehc_pkg::CLASS_ARP;
        end else if ((etype == cfg.ip_type) && match_eff) begin
            evt.cls = ehc_pkg::CLASS_IP;
        end else begin
            evt.cls = ehc_pkg::CLASS_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= 4'd0;
            match_reg   <= 1'b1;
            req_reg     <= 48'd0;
            type_hi_reg <= 8'd0;
        end else begin
            pos_reg     <= pos_next;
            match_reg   <= match_next;
            req_reg     <= req_next;
            type_hi_reg <= type_hi_next;
        end
    end

endmodule

// File: src/ehc_reply.sv
`include "eth_header_classify_reply_unit_assert.svh"

module ehc_reply (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ehc_pkg::cfg_t        cfg,
    input  logic                 evt_load,
    input  ehc_pkg::evt_t        evt,
    output ehc_pkg::reply_stat_t stat,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,
    output logic [2:0]           m_tuser,
    output logic                 m_tlast
);

    ehc_pkg::evt_t evt_reg, evt_next;
    logic          vld_reg, vld_next;
    logic [3:0]    idx_reg, idx_next;
    logic          is_ip, last, fire, finish;
    logic [7:0]    hdr_byte;
    logic [3:0]    src_idx;

    assign is_ip  = (evt_reg.cls == ehc_pkg::CLASS_IP);
    assign last   = !is_ip || (idx_reg == ehc_pkg::HDR_LAST);
    assign fire   = vld_reg && m_tready;
    assign finish = fire && last;

    assign stat.hold = vld_reg && !finish;

    assign src_idx = idx_reg - ehc_pkg::HDR_MAC_END;

    always_comb begin
        if (!is_ip) begin
            hdr_byte = 8'h00;
        end else if (idx_reg < ehc_pkg::HDR_MAC_END) begin
            hdr_byte = ehc_pkg::mac_byte(evt_reg.req_mac, idx_reg[2:0]);
        end else if (idx_reg < ehc_pkg::HDR_SRC_END) begin
            hdr_byte = ehc_pkg::mac_byte(cfg.local_mac, src_idx[2:0]);
        end else if (idx_reg == ehc_pkg::HDR_TYPE_HI) begin
            hdr_byte = evt_reg.etype[15:8];
        end else begin
            hdr_byte = evt_reg.etype[7:0];
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {4'd0, (is_ip ? idx_reg : 4'd0), hdr_byte};
    assign m_tuser  = {is_ip, evt_reg.cls};
    assign m_tlast  = last;

    always_comb begin
        evt_next = evt_reg;
        vld_next = vld_reg;
        idx_next = idx_reg;
        if (fire) begin
            if (last) begin
                vld_next = 1'b0;
            end else begin
                idx_next = idx_reg + 4'd1;
            end
        end
        if (evt_load) begin
            evt_next = evt;
            vld_next = 1'b1;
            idx_next = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            idx_reg <= 4'd0;
        end else begin
            vld_reg <= vld_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        evt_reg <= evt_next;
    end

    `EHC_ASSERT_SAME(a_idx_range, aclk, aresetn, vld_reg, idx_reg <= ehc_pkg::HDR_LAST)
    `EHC_ASSERT_SAME(a_single_non_ip, aclk, aresetn, vld_reg && !is_ip, idx_reg == 4'd0)
    `EHC_ASSERT_SAME(a_no_overrun, aclk, aresetn, evt_load, !vld_reg || finish)
    `EHC_ASSERT_NEXT(a_burst_steps, aclk, aresetn, fire && !last,
                     vld_reg && (idx_reg == $past(idx_reg) + 4'd1))

endmodule

// File: src/eth_header_classify_reply_unit.sv
// The result of frame byte 13 is offered in the cycle after that byte's transfer.
// Throughput: one frame byte per cycle while s_tready is high; an IP reply header is a
// burst of 14 result transfers that overlaps the following payload bytes, and a byte
// arriving at frame position 13, even one that starts a new frame, waits only while an
// earlier result or burst is still being delivered.
// Reset: synchronous, active low; clears frame tracking and the result stage and
// loads the configuration registers with their defaults.
module eth_header_classify_reply_unit (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write channel. Index 0 local MAC, 1 IP ethertype, 2 ARP ethertype.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [47:0] cfg_wdata,

    // Received frame bytes, one per transfer.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] frame_start

    // Classification results and reply header bytes.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] header_byte, [11:8] header_index, [15:12] zero
    output logic [2:0]  m_tuser,   // [1:0] frame_class, [2] byte_valid
    output logic        m_tlast    // last_of_run
);

    ehc_pkg::cfg_t        cfg;
    ehc_pkg::evt_t        evt;
    ehc_pkg::reply_stat_t stat;
    logic                 evt_load;

    // The configuration block holds the station MAC and the two ethertypes.
    // Writes are expected only while no frame work is outstanding.
    ehc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The parser tracks the byte position, compares the destination MAC,
    // captures the sender MAC and ethertype, and classifies on byte 13.
    ehc_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg),
        .stat     (stat),
        .evt_load (evt_load),
        .evt      (evt)
    );

    // The reply stage registers the classified frame and walks through the
    // reply header one byte per result transfer. ARP and unmatched frames
    // give a single result.
    ehc_reply u_reply (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .evt_load (evt_load),
        .evt      (evt),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
